// ===== design/sptt_pkg.sv =====
package sptt_pkg;

   localparam int MAX_NODES_DEF = 64;
   localparam int COST_BITS_DEF = 16;

   localparam int NODE_W      = 6;
   localparam int WEIGHT_W    = 16;
   localparam int NODES_CFG_W = 7;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic [WEIGHT_W-1:0]    NO_EDGE_RESET = 16'd999;
   localparam logic [NODES_CFG_W-1:0] NODES_RESET   = 7'd43;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_RUN  = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NODES_IN_USE  = 1'b0,
      CSR_NO_EDGE_VALUE = 1'b1
   } csr_index_type;

endpackage

// ===== design/sptt_if.sv =====
interface sptt_req_if;
   logic                             valid;
   logic                             ready;
   logic                             operation;
   logic [sptt_pkg::NODE_W-1:0]      from_node;
   logic [sptt_pkg::NODE_W-1:0]      to_node;
   logic [sptt_pkg::WEIGHT_W-1:0]    edge_weight;

   modport source (output valid, operation, from_node, to_node, edge_weight, input ready);
   modport sink   (input valid, operation, from_node, to_node, edge_weight, output ready);
endinterface

interface sptt_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [sptt_pkg::NODE_W-1:0]      path_node;
   logic [sptt_pkg::WEIGHT_W-1:0]    total_cost;
   logic                             unreachable;
   logic                             last;

   modport source (output valid, path_node, total_cost, unreachable, last, input ready);
   modport sink   (input valid, path_node, total_cost, unreachable, last, output ready);
endinterface

interface sptt_csr_if;
   logic                             valid;
   logic                             ready;
   logic [sptt_pkg::CSR_IDX_W-1:0]   index;
   logic [sptt_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/sptt_ram.sv =====
module sptt_ram #(
   parameter int WIDTH = sptt_pkg::COST_BITS_DEF,
   parameter int DEPTH = sptt_pkg::MAX_NODES_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== design/sptt_cost_unit.sv =====
module sptt_cost_unit #(
   parameter int COST_BITS = sptt_pkg::COST_BITS_DEF
) (
   input  logic [COST_BITS-1:0] op_a,
   input  logic [COST_BITS-1:0] op_b,
   input  logic [COST_BITS-1:0] op_ref,
   output logic [COST_BITS-1:0] sum,
   output logic                 less
);

   logic [COST_BITS:0] raw;

   always_comb begin
      raw  = {1'b0, op_a} + {1'b0, op_b};
      sum  = raw[COST_BITS] ? {COST_BITS{1'b1}} : raw[COST_BITS-1:0];
      less = sum < op_ref;
   end

endmodule

// ===== design/shortest_path_to_target_unit.sv =====
// Channel  Port      Dir  Moves
// req      req_chan  in   load one edge weight, or run a search from source to target
// rsp      rsp_chan  out  path nodes from target back to source, with total cost
// csr      csr_chan  in   writes of nodes_in_use and no_edge_value
//
// A load request is written to the weight table straight from idle. A run walks the
// cost RAM through its single read port: each scan pass and each relax pass walks node
// by node, one scan and one relax pass per settled node, before the target cost is
// checked and the first result is given. Each further path result needs a predecessor RAM read.
// After reset the weight table, 2^(2*log2(MAX_NODES)) entries (4096 by default), is
// swept once, one entry per cycle; no request is taken meanwhile. The block takes no request
// while a run is in progress or a result waits on a stalled rsp channel.
module shortest_path_to_target_unit #(
   parameter int MAX_NODES = sptt_pkg::MAX_NODES_DEF,
   parameter int COST_BITS = sptt_pkg::COST_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   sptt_req_if.sink   req_chan,
   sptt_rsp_if.source rsp_chan,
   sptt_csr_if.sink   csr_chan
);

   import sptt_pkg::*;

   localparam int NB = $clog2(MAX_NODES);
   localparam int CB = $clog2(MAX_NODES + 1);
   localparam int TB = 2 * NB;
   localparam int CW = COST_BITS;

   localparam logic [8:0]       MAX_N9   = 9'(MAX_NODES);
   localparam logic [CW-1:0]    COST_CAP = {CW{1'b1}};
   localparam logic [CW+15:0]   RST_W    = {{CW{1'b0}}, NO_EDGE_RESET};
   localparam logic [CW-1:0]    TBL_RST  = RST_W[CW-1:0];

   typedef enum logic [8:0] {
      ST_CLEAR  = 9'b000000001,
      ST_IDLE   = 9'b000000010,
      ST_INIT   = 9'b000000100,
      ST_SCAN   = 9'b000001000,
      ST_RELAX  = 9'b000010000,
      ST_CHECK  = 9'b000100000,
      ST_DECIDE = 9'b001000000,
      ST_OUT    = 9'b010000000,
      ST_PRED   = 9'b100000000
   } state_type;

   state_type              state_ff, state_in;
   logic [TB-1:0]          clr_ff, clr_in;
   logic [NODES_CFG_W-1:0] nodes_ff, nodes_in;
   logic [WEIGHT_W-1:0]    no_edge_ff, no_edge_in;
   logic [MAX_NODES-1:0]   settled_ff, settled_in;
   logic [CB-1:0]          cnt_ff, cnt_in;
   logic                   found_ff, found_in;
   logic [CB-1:0]          n_ff, n_in;
   logic [CW-1:0]          lim_ff, lim_in;
   logic [NB-1:0]          src_ff, src_in;
   logic [NB-1:0]          dst_ff, dst_in;
   logic [CW-1:0]          best_ff, best_in;
   logic [NB-1:0]          cur_ff, cur_in;
   logic [NB-1:0]          node_ff, node_in;
   logic [CB-1:0]          k_ff, k_in;
   logic [CW-1:0]          total_ff, total_in;
   logic [NODE_W-1:0]      out_node_ff, out_node_in;
   logic [WEIGHT_W-1:0]    out_cost_ff, out_cost_in;
   logic                   out_unr_ff, out_unr_in;
   logic                   out_last_ff, out_last_in;

   logic                   req_fire, rsp_fire, csr_fire;
   logic [8:0]             from9, to9, nodes9, n9, dst9, pred9;
   logic [CW+15:0]         lim_w, wt_w, cap_w, cost_rd_w, total_w;
   logic [CW-1:0]          lim_new, wt_new;
   logic                   load_ok, run_ok;
   logic [NB-1:0]          idx, jdx;
   logic [CB-1:0]          cnt_m1, n_m1, k_p1;
   logic                   issue_end, have_data;

   logic                   tbl_wr_en;
   logic [TB-1:0]          tbl_wr_addr, tbl_rd_addr;
   logic [CW-1:0]          tbl_wr_data, w_rd;
   logic                   cost_wr_en, relax_wr;
   logic [NB-1:0]          cost_wr_addr, cost_rd_addr;
   logic [CW-1:0]          cost_wr_data, cost_rd;
   logic [NB-1:0]          pred_rd;

   logic [CW-1:0]          op_a, op_b, op_ref, unit_sum;
   logic                   unit_less;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign rsp_chan.valid = (state_ff == ST_OUT);
   assign rsp_chan.path_node   = out_node_ff;
   assign rsp_chan.total_cost  = out_cost_ff;
   assign rsp_chan.unreachable = out_unr_ff;
   assign rsp_chan.last        = out_last_ff;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;
   assign csr_fire = csr_chan.valid && csr_chan.ready;

   always_comb begin
      from9   = {3'b000, req_chan.from_node};
      to9     = {3'b000, req_chan.to_node};
      nodes9  = {2'b00, nodes_ff};
      if (nodes9 < 9'd2) begin
         n9 = 9'd2;
      end else if (nodes9 > MAX_N9) begin
         n9 = MAX_N9;
      end else begin
         n9 = nodes9;
      end
      cap_w   = {16'd0, COST_CAP};
      lim_w   = {{CW{1'b0}}, no_edge_ff};
      lim_new = (lim_w > cap_w) ? COST_CAP : lim_w[CW-1:0];
      wt_w    = {{CW{1'b0}}, req_chan.edge_weight};
      wt_new  = (wt_w > cap_w) ? COST_CAP : wt_w[CW-1:0];
      load_ok = (from9 < MAX_N9) && (to9 < MAX_N9);
      run_ok  = (from9 < n9) && (to9 < n9);

      idx       = cnt_ff[NB-1:0];
      cnt_m1    = cnt_ff - CB'(1);
      jdx       = cnt_m1[NB-1:0];
      n_m1      = n_ff - CB'(1);
      k_p1      = k_ff + CB'(1);
      issue_end = (cnt_ff == n_ff);
      have_data = (cnt_ff != '0);

      dst9      = {{(9-NB){1'b0}}, dst_ff};
      pred9     = {{(9-NB){1'b0}}, pred_rd};
      cost_rd_w = {16'd0, cost_rd};
      total_w   = {16'd0, total_ff};
   end

   always_comb begin
      case (state_ff)
         ST_SCAN: begin
            op_a   = cost_rd;
            op_b   = '0;
            op_ref = best_ff;
         end
         ST_RELAX: begin
            op_a   = best_ff;
            op_b   = w_rd;
            op_ref = cost_rd;
         end
         default: begin
            op_a   = cost_rd;
            op_b   = '0;
            op_ref = lim_ff;
         end
      endcase
   end

   sptt_cost_unit #(
      .COST_BITS (CW)
   ) u_cost (
      .op_a   (op_a),
      .op_b   (op_b),
      .op_ref (op_ref),
      .sum    (unit_sum),
      .less   (unit_less)
   );

   always_comb begin
      tbl_wr_en   = 1'b0;
      tbl_wr_addr = {from9[NB-1:0], to9[NB-1:0]};
      tbl_wr_data = wt_new;
      if (state_ff == ST_CLEAR) begin
         tbl_wr_en   = 1'b1;
         tbl_wr_addr = clr_ff;
         tbl_wr_data = (clr_ff[TB-1:NB] == clr_ff[NB-1:0]) ? '0 : TBL_RST;
      end else if (req_fire && req_chan.operation == OP_LOAD && load_ok) begin
         tbl_wr_en = 1'b1;
      end
      tbl_rd_addr = {cur_ff, idx};

      relax_wr = (state_ff == ST_RELAX) && have_data && !settled_ff[jdx] && unit_less;
      if (state_ff == ST_INIT) begin
         cost_wr_en   = 1'b1;
         cost_wr_addr = idx;
         cost_wr_data = (idx == src_ff) ? '0 : lim_ff;
      end else begin
         cost_wr_en   = relax_wr;
         cost_wr_addr = jdx;
         cost_wr_data = unit_sum;
      end
      cost_rd_addr = (state_ff == ST_CHECK) ? dst_ff : idx;
   end

   sptt_ram #(
      .WIDTH (CW),
      .DEPTH (1 << TB)
   ) u_weight_ram (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_addr (tbl_rd_addr),
      .rd_data (w_rd)
   );

   sptt_ram #(
      .WIDTH (CW),
      .DEPTH (MAX_NODES)
   ) u_cost_ram (
      .clock   (clock),
      .wr_en   (cost_wr_en),
      .wr_addr (cost_wr_addr),
      .wr_data (cost_wr_data),
      .rd_addr (cost_rd_addr),
      .rd_data (cost_rd)
   );

   sptt_ram #(
      .WIDTH (NB),
      .DEPTH (MAX_NODES)
   ) u_pred_ram (
      .clock   (clock),
      .wr_en   (relax_wr),
      .wr_addr (jdx),
      .wr_data (cur_ff),
      .rd_addr (node_ff),
      .rd_data (pred_rd)
   );

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      nodes_in    = nodes_ff;
      no_edge_in  = no_edge_ff;
      settled_in  = settled_ff;
      cnt_in      = cnt_ff;
      found_in    = found_ff;
      n_in        = n_ff;
      lim_in      = lim_ff;
      src_in      = src_ff;
      dst_in      = dst_ff;
      best_in     = best_ff;
      cur_in      = cur_ff;
      node_in     = node_ff;
      k_in        = k_ff;
      total_in    = total_ff;
      out_node_in = out_node_ff;
      out_cost_in = out_cost_ff;
      out_unr_in  = out_unr_ff;
      out_last_in = out_last_ff;

      if (csr_fire) begin
         case (csr_chan.index)
            CSR_NODES_IN_USE:  nodes_in   = csr_chan.data[NODES_CFG_W-1:0];
            CSR_NO_EDGE_VALUE: no_edge_in = csr_chan.data;
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + TB'(1);
            if (&clr_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire && req_chan.operation == OP_RUN) begin
               n_in       = n9[CB-1:0];
               lim_in     = lim_new;
               src_in     = from9[NB-1:0];
               dst_in     = to9[NB-1:0];
               settled_in = '0;
               cnt_in     = '0;
               if (run_ok) begin
                  state_in = ST_INIT;
               end else begin
                  out_node_in = req_chan.to_node;
                  out_cost_in = '0;
                  out_unr_in  = 1'b1;
                  out_last_in = 1'b1;
                  state_in    = ST_OUT;
               end
            end
         end
         ST_INIT: begin
            cnt_in = cnt_ff + CB'(1);
            if (cnt_ff == n_m1) begin
               cnt_in   = '0;
               best_in  = lim_ff;
               found_in = 1'b0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (have_data && !settled_ff[jdx] && unit_less) begin
               best_in  = cost_rd;
               cur_in   = jdx;
               found_in = 1'b1;
            end
            if (issue_end) begin
               cnt_in = '0;
               if (found_in) begin
                  settled_in[cur_in] = 1'b1;
                  state_in           = ST_RELAX;
               end else begin
                  state_in = ST_CHECK;
               end
            end else begin
               cnt_in = cnt_ff + CB'(1);
            end
         end
         ST_RELAX: begin
            if (issue_end) begin
               cnt_in   = '0;
               best_in  = lim_ff;
               found_in = 1'b0;
               state_in = ST_SCAN;
            end else begin
               cnt_in = cnt_ff + CB'(1);
            end
         end
         ST_CHECK: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            out_node_in = dst9[NODE_W-1:0];
            if (unit_less) begin
               total_in    = cost_rd;
               node_in     = dst_ff;
               k_in        = '0;
               out_cost_in = cost_rd_w[WEIGHT_W-1:0];
               out_unr_in  = 1'b0;
               out_last_in = (dst_ff == src_ff) || (n_m1 == '0);
            end else begin
               out_cost_in = '0;
               out_unr_in  = 1'b1;
               out_last_in = 1'b1;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_fire) begin
               state_in = out_last_ff ? ST_IDLE : ST_PRED;
            end
         end
         ST_PRED: begin
            node_in     = pred_rd;
            k_in        = k_p1;
            out_node_in = pred9[NODE_W-1:0];
            out_cost_in = total_w[WEIGHT_W-1:0];
            out_unr_in  = 1'b0;
            out_last_in = (pred_rd == src_ff) || (k_p1 == n_m1);
            state_in    = ST_OUT;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_ff     <= '0;
         nodes_ff   <= NODES_RESET;
         no_edge_ff <= NO_EDGE_RESET;
         settled_ff <= '0;
         cnt_ff     <= '0;
         found_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         nodes_ff   <= nodes_in;
         no_edge_ff <= no_edge_in;
         settled_ff <= settled_in;
         cnt_ff     <= cnt_in;
         found_ff   <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      lim_ff      <= lim_in;
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      best_ff     <= best_in;
      cur_ff      <= cur_in;
      node_ff     <= node_in;
      k_ff        <= k_in;
      total_ff    <= total_in;
      out_node_ff <= out_node_in;
      out_cost_ff <= out_cost_in;
      out_unr_ff  <= out_unr_in;
      out_last_ff <= out_last_in;
   end

endmodule
